FILE: hdl/npcs_pkg.sv
// Package for the nearest palette colour search block.
// Holds the field widths, opcodes, palette entry layout and the command and
// status groups that pass between the controller and the datapath.
package npcs_pkg;

  // Field widths of the item and result beats
  localparam int unsigned L_W    = 13;
  localparam int unsigned AB_W   = 14;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 7;

  // Widths inside the distance datapath
  localparam int unsigned DL_W   = L_W;        // |delta L| fits the field width
  localparam int unsigned DAB_W  = AB_W;       // |delta a|, |delta b| up to 16383
  localparam int unsigned SQL_W  = 2 * DL_W;
  localparam int unsigned SQAB_W = 2 * DAB_W;
  localparam int unsigned DIST_W = 30;

  // Opcodes carried by an input beat
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // One stored palette colour
  typedef struct packed {
    logic        [L_W-1:0]  l;
    logic signed [AB_W-1:0] a;
    logic signed [AB_W-1:0] b;
  } entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic wr_en;        // store the incoming entry
    logic load_target;  // capture the query colour
    logic rd_en;        // read one palette entry this cycle
    logic rd_first;     // the entry read is the first of the search
    logic rd_last;      // the entry read is the last of the search
    logic out_load;     // move the answer into the output register
    logic out_empty;    // the answer is for an empty palette
  } cmd_t;

  // Status from the datapath back to the controller
  typedef struct packed {
    logic done;         // best match is final
    logic out_free;     // output register can take a new result
  } status_t;

endpackage

FILE: hdl/nearest_palette_color_search.sv
// Nearest palette colour search, top level: palette_count register, controller, datapath.
// A write beat is stored when it is accepted. A query of n = min(palette_count, PALETTE_DEPTH)
// entries holds the input until its result is loaded into the output register;
// an empty palette answers without any reads; one read per cycle.
// Reset clears the count to zero and all control state; the palette is undefined until written.
// Depends on npcs_pkg, npcs_ctrl and npcs_datapath.
module nearest_palette_color_search #(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [npcs_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic [npcs_pkg::SLOT_W-1:0]       entry_index_i,
  input  logic [npcs_pkg::L_W-1:0]          l_value_i,
  input  logic signed [npcs_pkg::AB_W-1:0]  a_value_i,
  input  logic signed [npcs_pkg::AB_W-1:0]  b_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [npcs_pkg::IDX_W-1:0]        color_index_o,
  output logic                              palette_empty_o
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);

  logic [npcs_pkg::CNT_W-1:0] palette_count_q;
  logic [CW-1:0]              limit;
  npcs_pkg::cmd_t             cmd;
  npcs_pkg::status_t          status;
  logic [AW-1:0]              rd_addr;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      palette_count_q <= '0;
    end else if (cfg_we_i) begin
      palette_count_q <= cfg_wdata_i;
    end
  end

  // Search length saturates at the store depth
  assign limit = (32'(palette_count_q) > 32'(PALETTE_DEPTH)) ? CW'(PALETTE_DEPTH)
                                                             : CW'(palette_count_q);

  npcs_ctrl #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .limit_i    (limit),
    .status_i   (status),
    .cmd_o      (cmd),
    .rd_addr_o  (rd_addr)
  );

  npcs_datapath #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rd_addr_i       (rd_addr),
    .status_o        (status),
    .entry_index_i   (entry_index_i),
    .l_value_i       (l_value_i),
    .a_value_i       (a_value_i),
    .b_value_i       (b_value_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .color_index_o   (color_index_o),
    .palette_empty_o (palette_empty_o)
  );

  // An empty-palette answer always points at entry zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && palette_empty_o) |-> (color_index_o == '0))
    else $error("empty palette result with non-zero index");

  // A new result only appears after a query held the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a query in flight");

  // The search finishes only while its query still blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.done |-> in_stall_o)
    else $error("search completed while controller idle");

endmodule

FILE: hdl/npcs_ctrl.sv
// Controller of the nearest palette colour search.
// Sequences the palette reads of a query and the hand-over of the result;
// depends on npcs_pkg for the command and status types.
module npcs_ctrl #(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_stall_o,
  input  logic                                      opcode_i,
  input  logic [$clog2(PALETTE_DEPTH+1)-1:0]        limit_i,
  input  npcs_pkg::status_t                         status_i,
  output npcs_pkg::cmd_t                            cmd_o,
  output logic [((PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1)-1:0] rd_addr_o
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(PALETTE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_DELIVER
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   addr_q;
  logic            empty_q;
  logic            accept;
  logic [CW-1:0]   addr_nx;
  logic            last_rd;

  // An item is taken only while no query is in flight
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // The read in progress is the last one when the next address reaches the limit
  assign addr_nx = CW'(addr_q) + CW'(1);
  assign last_rd = (addr_nx == limit_i);

  // Commands decoded from the state and the accepted beat
  always_comb begin
    cmd_o             = '0;
    cmd_o.wr_en       = accept && (opcode_i == npcs_pkg::OP_WRITE);
    cmd_o.load_target = accept && (opcode_i == npcs_pkg::OP_QUERY);
    cmd_o.rd_en       = (state_q == ST_ISSUE);
    cmd_o.rd_first    = (state_q == ST_ISSUE) && (addr_q == '0);
    cmd_o.rd_last     = (state_q == ST_ISSUE) && last_rd;
    cmd_o.out_empty   = empty_q;
    case (state_q)
      ST_DRAIN:   cmd_o.out_load = status_i.done && status_i.out_free;
      ST_DELIVER: cmd_o.out_load = status_i.out_free;
      default:    cmd_o.out_load = 1'b0;
    endcase
  end

  assign rd_addr_o = addr_q;

  // State and read address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      addr_q  <= '0;
      empty_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (accept && (opcode_i == npcs_pkg::OP_QUERY)) begin
            addr_q <= '0;
            if (limit_i == '0) begin
              empty_q <= 1'b1;
              state_q <= ST_DELIVER;
            end else begin
              empty_q <= 1'b0;
              state_q <= ST_ISSUE;
            end
          end
        end
        ST_ISSUE: begin
          if (last_rd) begin
            state_q <= ST_DRAIN;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        ST_DRAIN: begin
          if (status_i.done) begin
            state_q <= status_i.out_free ? ST_IDLE : ST_DELIVER;
          end
        end
        ST_DELIVER: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: hdl/npcs_datapath.sv
// Datapath of the nearest palette colour search.
// Palette memory, distance pipeline, best-match tracking and output register;
// depends on npcs_pkg for widths, entry layout and command/status types.
module npcs_datapath #(
  parameter int unsigned PALETTE_DEPTH = 64
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  npcs_pkg::cmd_t                       cmd_i,
  input  logic [((PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1)-1:0] rd_addr_i,
  output npcs_pkg::status_t                    status_o,
  input  logic [npcs_pkg::SLOT_W-1:0]          entry_index_i,
  input  logic [npcs_pkg::L_W-1:0]             l_value_i,
  input  logic signed [npcs_pkg::AB_W-1:0]     a_value_i,
  input  logic signed [npcs_pkg::AB_W-1:0]     b_value_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [npcs_pkg::IDX_W-1:0]           color_index_o,
  output logic                                 palette_empty_o
);

  localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

  // Palette store and query target
  npcs_pkg::entry_t mem [PALETTE_DEPTH];
  npcs_pkg::entry_t tgt_q;
  npcs_pkg::entry_t wr_entry;
  logic             wr_ok;

  // Stage 1: entry read
  npcs_pkg::entry_t rdata_q;
  logic             s1_vld_q, s1_first_q, s1_last_q;
  logic [AW-1:0]    s1_idx_q;

  // Stage 2: absolute differences
  logic signed [npcs_pkg::L_W:0]    dl_s;
  logic signed [npcs_pkg::AB_W:0]   da_s, db_s;
  logic [npcs_pkg::DL_W-1:0]        dl_d, dl_q;
  logic [npcs_pkg::DAB_W-1:0]       da_d, da_q, db_d, db_q;
  logic                             s2_vld_q, s2_first_q, s2_last_q;
  logic [AW-1:0]                    s2_idx_q;

  // Stage 3: squares
  logic [npcs_pkg::SQL_W-1:0]       sql_d, sql_q;
  logic [npcs_pkg::SQAB_W-1:0]      sqa_d, sqa_q, sqb_d, sqb_q;
  logic                             s3_vld_q, s3_first_q, s3_last_q;
  logic [AW-1:0]                    s3_idx_q;

  // Stage 4: sum and compare
  logic [npcs_pkg::DIST_W-1:0]      sq_dist;
  logic [npcs_pkg::DIST_W-1:0]      best_dist_q;
  logic [AW-1:0]                    best_idx_q;
  logic                             done_q;

  // Output register
  logic                             out_valid_q;
  logic [npcs_pkg::IDX_W-1:0]       color_index_q;
  logic                             palette_empty_q;

  // Writes beyond the store are dropped
  assign wr_ok      = cmd_i.wr_en &&
                      (32'(entry_index_i) < 32'(PALETTE_DEPTH));
  assign wr_entry.l = l_value_i;
  assign wr_entry.a = a_value_i;
  assign wr_entry.b = b_value_i;

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem[AW'(entry_index_i)] <= wr_entry;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  // Query colour held for the whole search
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_target) begin
      tgt_q <= wr_entry;
    end
  end

  // Absolute differences per channel
  always_comb begin
    dl_s = $signed({1'b0, rdata_q.l}) - $signed({1'b0, tgt_q.l});
    da_s = $signed({rdata_q.a[npcs_pkg::AB_W-1], rdata_q.a})
         - $signed({tgt_q.a[npcs_pkg::AB_W-1], tgt_q.a});
    db_s = $signed({rdata_q.b[npcs_pkg::AB_W-1], rdata_q.b})
         - $signed({tgt_q.b[npcs_pkg::AB_W-1], tgt_q.b});
    dl_d = dl_s[npcs_pkg::L_W]  ? npcs_pkg::DL_W'(-dl_s)  : npcs_pkg::DL_W'(dl_s);
    da_d = da_s[npcs_pkg::AB_W] ? npcs_pkg::DAB_W'(-da_s) : npcs_pkg::DAB_W'(da_s);
    db_d = db_s[npcs_pkg::AB_W] ? npcs_pkg::DAB_W'(-db_s) : npcs_pkg::DAB_W'(db_s);
  end

  // Squares, one small multiplier per channel
  assign sql_d = npcs_pkg::SQL_W'(dl_q)  * npcs_pkg::SQL_W'(dl_q);
  assign sqa_d = npcs_pkg::SQAB_W'(da_q) * npcs_pkg::SQAB_W'(da_q);
  assign sqb_d = npcs_pkg::SQAB_W'(db_q) * npcs_pkg::SQAB_W'(db_q);

  // Exact squared distance
  assign sq_dist = npcs_pkg::DIST_W'(sql_q) + npcs_pkg::DIST_W'(sqa_q)
                 + npcs_pkg::DIST_W'(sqb_q);

  // Pipeline payload, no reset needed
  always_ff @(posedge clk_i) begin
    s1_idx_q <= rd_addr_i;
    dl_q     <= dl_d;
    da_q     <= da_d;
    db_q     <= db_d;
    s2_idx_q <= s1_idx_q;
    sql_q    <= sql_d;
    sqa_q    <= sqa_d;
    sqb_q    <= sqb_d;
    s3_idx_q <= s2_idx_q;
  end

  // Pipeline control bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s3_vld_q   <= 1'b0;
      s3_first_q <= 1'b0;
      s3_last_q  <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.rd_en;
      s1_first_q <= cmd_i.rd_first;
      s1_last_q  <= cmd_i.rd_last;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s3_vld_q   <= s2_vld_q;
      s3_first_q <= s2_first_q;
      s3_last_q  <= s2_last_q;
      done_q     <= s3_vld_q && s3_last_q;
    end
  end

  // Best match: a later entry wins only when strictly closer
  always_ff @(posedge clk_i) begin
    if (s3_vld_q && (s3_first_q || (sq_dist < best_dist_q))) begin
      best_dist_q <= sq_dist;
      best_idx_q  <= s3_idx_q;
    end
  end

  // Output register, free when empty or being taken
  assign status_o.done     = done_q;
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      color_index_q   <= cmd_i.out_empty ? '0 : npcs_pkg::IDX_W'(best_idx_q);
      palette_empty_q <= cmd_i.out_empty;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign color_index_o   = color_index_q;
  assign palette_empty_o = palette_empty_q;

endmodule
